### design/rpsl_pkg.sv
// Shared constants and field layout for the run end physical span lookup.
`default_nettype none

package rpsl_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Field widths.
    localparam int VAL_W = 63;
    localparam int CNT_W = 11;
    localparam int SUM_W = VAL_W + 1;

    // Input payload layout, lowest bits first.
    localparam int ENTRY_LSB  = 0;
    localparam int RUNEND_LSB = ENTRY_LSB + 10;
    localparam int OFFSET_LSB = RUNEND_LSB + VAL_W;
    localparam int LENGTH_LSB = OFFSET_LSB + VAL_W;
    localparam int S_FIELDS_W = LENGTH_LSB + VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Result payload layout, lowest bits first.
    localparam int PLEN_LSB   = CNT_W;
    localparam int M_FIELDS_W = 2 * CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Request kinds carried in tuser.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

endpackage

`default_nettype wire

### design/run_end_physical_span_lookup.sv
// Top level of the run end physical span lookup: request decode, two searches, result register.
//
// Usage: requests arrive on the s_ channel. A load request (tuser = 0) writes one run end
// into the table in the cycle it is accepted and produces no result. A query request
// (tuser = 1) runs up to two upper-bound binary searches over the table and produces one result
// on the m_ channel: the physical offset and the physical run count of the slice.
// The run_count register is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while the block is idle, which the block itself does not enforce. A query passes
// through PREP, the first search in RUN1, START2, the second search in RUN2 and DONE, where
// its result is written to the result register; each search makes at most ceil(log2(n+1))
// probes for n valid entries and is skipped when it has nothing to search. The searches read
// the table one probe per cycle through the single RAM read port. One request is worked on
// at a time; s_tready is high only between requests, so after a load the next request can
// be taken at once, while a query keeps s_tready low until its result is in the register.
// The result sits in an output register, so the next request is accepted while a result
// waits. If the receiver stalls, a finished query waits until the register is free.
// Reset clears the control state, the result valid flag and run_count; the table contents
// are undefined until loaded.
`default_nettype none

module run_end_physical_span_lookup (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration: run_count.
    input  wire logic                             cfg_wr_en,
    input  wire logic [rpsl_pkg::CNT_W-1:0]       cfg_wr_data,
    // Request channel.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata fields, lowest bit up: entry_index[9:0], run_end[72:10],
    // slice_start[135:73], logical_length[198:136], zero pad [199].
    input  wire logic [rpsl_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser fields: req_type[0].
    input  wire logic [0:0]                       s_tuser,
    // Result channel.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata fields, lowest bit up: first_run[10:0], physical_length[21:11],
    // zero pad [23:22].
    output logic      [rpsl_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int CNT_W = rpsl_pkg::CNT_W;
    localparam int VAL_W = rpsl_pkg::VAL_W;
    localparam int IDX_W = rpsl_pkg::IDX_W;
    localparam int SUM_W = rpsl_pkg::SUM_W;

    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_ZERO  = '0;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(rpsl_pkg::TABLE_DEPTH);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_RUN1   = 3'd2;
    localparam logic [2:0] ST_START2 = 3'd3;
    localparam logic [2:0] ST_RUN2   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] run_count_reg;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] poff_reg, poff_next;
    logic [CNT_W-1:0] plen_reg, plen_next;
    logic [VAL_W-1:0] off_reg, off_next;
    logic [VAL_W-1:0] lenm1_reg, lenm1_next;
    logic             lenz_reg, lenz_next;
    logic [VAL_W-1:0] last_reg, last_next;
    logic             m_tvalid_reg;
    logic [rpsl_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic             s_accept;
    logic             is_query;
    logic [VAL_W-1:0] in_offset;
    logic [VAL_W-1:0] in_length;
    logic [CNT_W-1:0] in_count_clamped;
    logic [VAL_W-1:0] rd_data;
    logic             ram_wr_en;
    logic [VAL_W-1:0] key;
    logic             go_right;
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] upd_first;
    logic [CNT_W-1:0] upd_count;
    logic [CNT_W-1:0] count2;
    logic [SUM_W-1:0] end_sum;
    logic             out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign is_query  = (s_tuser[0] == rpsl_pkg::REQ_QUERY);
    assign in_offset = s_tdata[rpsl_pkg::OFFSET_LSB +: VAL_W];
    assign in_length = s_tdata[rpsl_pkg::LENGTH_LSB +: VAL_W];
    assign ram_wr_en = s_accept && (s_tuser[0] == rpsl_pkg::REQ_LOAD);
    assign out_free  = !m_tvalid_reg || m_tready;

    // A count above the table depth is limited to the depth.
    assign in_count_clamped = (run_count_reg > DEPTH_CNT) ? DEPTH_CNT : run_count_reg;

    // Run end table.
    rpsl_ram #(
        .WIDTH (VAL_W),
        .DEPTH (rpsl_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (s_tdata[rpsl_pkg::ENTRY_LSB +: IDX_W]),
        .wr_data (s_tdata[rpsl_pkg::RUNEND_LSB +: VAL_W]),
        .rd_addr (mid_next[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // One halving step on the entry that was read for the pending probe.
    assign key       = (state_reg == ST_RUN2) ? last_reg : off_reg;
    assign go_right  = !(key < rd_data);
    assign half      = count_reg >> 1;
    assign upd_first = go_right ? (mid_reg + CNT_ONE) : first_reg;
    assign upd_count = go_right ? (count_reg - half - CNT_ONE) : half;

    // Span of the second search and the slice end sum, with a carry bit for saturation.
    assign count2  = n_reg - first_reg;
    assign end_sum = {1'b0, off_reg} + {1'b0, lenm1_reg};

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        first_next = first_reg;
        count_next = count_reg;
        mid_next   = mid_reg;
        poff_next  = poff_reg;
        plen_next  = plen_reg;
        off_next   = off_reg;
        lenm1_next = lenm1_reg;
        lenz_next  = lenz_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && is_query) begin
                    off_next   = in_offset;
                    lenm1_next = in_length - VAL_W'(1);
                    lenz_next  = (in_length == '0);
                    n_next     = in_count_clamped;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                last_next  = end_sum[VAL_W] ? '1 : end_sum[VAL_W-1:0];
                first_next = CNT_ZERO;
                poff_next  = CNT_ZERO;
                if (n_reg == CNT_ZERO) begin
                    state_next = ST_START2;
                end else begin
                    count_next = n_reg;
                    mid_next   = n_reg >> 1;
                    state_next = ST_RUN1;
                end
            end
            ST_RUN1: begin
                first_next = upd_first;
                count_next = upd_count;
                mid_next   = upd_first + (upd_count >> 1);
                if (upd_count == CNT_ZERO) begin
                    poff_next  = upd_first;
                    state_next = ST_START2;
                end
            end
            ST_START2: begin
                if (lenz_reg) begin
                    plen_next  = CNT_ZERO;
                    state_next = ST_DONE;
                end else if (count2 == CNT_ZERO) begin
                    plen_next  = CNT_ONE;
                    state_next = ST_DONE;
                end else begin
                    count_next = count2;
                    mid_next   = first_reg + (count2 >> 1);
                    state_next = ST_RUN2;
                end
            end
            ST_RUN2: begin
                first_next = upd_first;
                count_next = upd_count;
                mid_next   = upd_first + (upd_count >> 1);
                if (upd_count == CNT_ZERO) begin
                    plen_next  = upd_first - poff_reg + CNT_ONE;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            run_count_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                run_count_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Search datapath and result payload.
    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        first_reg <= first_next;
        count_reg <= count_next;
        mid_reg   <= mid_next;
        poff_reg  <= poff_next;
        plen_reg  <= plen_next;
        off_reg   <= off_next;
        lenm1_reg <= lenm1_next;
        lenz_reg  <= lenz_next;
        last_reg  <= last_next;
        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= rpsl_pkg::M_TDATA_W'({plen_reg, poff_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // A probe is pending only while the search span is not empty.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN1 || state_reg == ST_RUN2) |-> (count_reg != CNT_ZERO))
        else $error("search step with empty span");

    // The pending probe is the midpoint of the current span.
    a_mid_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN1 || state_reg == ST_RUN2)
        |-> (mid_reg == first_reg + (count_reg >> 1)))
        else $error("probe address is not the span midpoint");

    // Probes stay inside the valid part of the table.
    a_mid_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN1 || state_reg == ST_RUN2) |-> (mid_reg < n_reg))
        else $error("probe beyond the valid entries");

    // A result is only produced from the finishing state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the finishing state");
`endif

endmodule

`default_nettype wire

### design/rpsl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rpsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### sim/tb_run_end_physical_span_lookup.sv
// Self-checking testbench for the run end physical span lookup: directed table, then random phases.
module tb_run_end_physical_span_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VAL_W       = rpsl_pkg::VAL_W;
    localparam int CNT_W       = rpsl_pkg::CNT_W;
    localparam int IDX_W       = rpsl_pkg::IDX_W;
    localparam int TABLE_DEPTH = rpsl_pkg::TABLE_DEPTH;
    localparam int S_TDATA_W   = rpsl_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = rpsl_pkg::M_TDATA_W;
    localparam int ENTRY_LSB   = rpsl_pkg::ENTRY_LSB;
    localparam int RUNEND_LSB  = rpsl_pkg::RUNEND_LSB;
    localparam int OFFSET_LSB  = rpsl_pkg::OFFSET_LSB;
    localparam int LENGTH_LSB  = rpsl_pkg::LENGTH_LSB;
    localparam int PLEN_LSB    = rpsl_pkg::PLEN_LSB;
    localparam logic REQ_LOAD  = rpsl_pkg::REQ_LOAD;
    localparam logic REQ_QUERY = rpsl_pkg::REQ_QUERY;

    localparam logic [VAL_W-1:0] MAX63 = {VAL_W{1'b1}};
    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        logic [CNT_W-1:0] phys_off;
        logic [CNT_W-1:0] phys_len;
    } span_t;

    typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_COUNT} row_op_t;

    // One directed row: for ROW_COUNT the run_end column holds the new run_count.
    typedef struct packed {
        row_op_t          op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] run_end;
        logic [VAL_W-1:0] offset;
        logic [VAL_W-1:0] length;
        logic             pinned;
        span_t            span;
    } drow_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BEAT, RX_STARVE} rx_mode_t;

    localparam int DIR_ROWS = 22;

    // Table 10, 20, 30 in the first three entries; expected spans given where they are obvious.
    drow_t dir_rows [DIR_ROWS] = '{
        '{ROW_QUERY, 10'd0,   63'd0,  63'd0,   63'd0,   1'b1, '{11'd0, 11'd0}},
        '{ROW_QUERY, 10'd0,   63'd0,  MAX63,   MAX63,   1'b1, '{11'd0, 11'd1}},
        '{ROW_LOAD,  10'd0,   63'd10, 63'd0,   63'd0,   1'b0, '{11'd0, 11'd0}},
        '{ROW_LOAD,  10'd1,   63'd20, 63'd0,   63'd0,   1'b0, '{11'd0, 11'd0}},
        '{ROW_LOAD,  10'd2,   63'd30, 63'd0,   63'd0,   1'b0, '{11'd0, 11'd0}},
        '{ROW_LOAD,  10'd1023, MAX63, 63'd0,   63'd0,   1'b0, '{11'd0, 11'd0}},
        '{ROW_LOAD,  10'd682, 63'h2AAA_AAAA_AAAA_AAAA, 63'd0, 63'd0, 1'b0, '{11'd0, 11'd0}},
        '{ROW_COUNT, 10'd0,   63'd3,  63'd0,   63'd0,   1'b0, '{11'd0, 11'd0}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd0,   63'd0,   1'b1, '{11'd0, 11'd0}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd9,   63'd1,   1'b1, '{11'd0, 11'd1}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd10,  63'd1,   1'b1, '{11'd1, 11'd1}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd15,  63'd10,  1'b0, '{11'd0, 11'd0}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd30,  63'd1,   1'b1, '{11'd3, 11'd1}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd0,   MAX63,   1'b1, '{11'd0, 11'd4}},
        '{ROW_QUERY, 10'd0,   63'd0,  MAX63,   MAX63,   1'b1, '{11'd3, 11'd1}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd5,   MAX63,   1'b0, '{11'd0, 11'd0}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd20,  63'd0,   1'b1, '{11'd2, 11'd0}},
        '{ROW_LOAD,  10'd1,   63'd5,  63'd0,   63'd0,   1'b0, '{11'd0, 11'd0}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd7,   63'd0,   1'b0, '{11'd0, 11'd0}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd6,   63'd25,  1'b0, '{11'd0, 11'd0}},
        '{ROW_COUNT, 10'd0,   63'd0,  63'd0,   63'd0,   1'b0, '{11'd0, 11'd0}},
        '{ROW_QUERY, 10'd0,   63'd0,  63'd100, 63'd100, 1'b1, '{11'd0, 11'd1}}
    };

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [0:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predictor state: our own copy of the run end table and the run_count register.
    logic [VAL_W-1:0] shadow_ends [TABLE_DEPTH];
    logic [CNT_W-1:0] valid_runs = '0;
    span_t            span_q [$];
    int               mismatches = 0;
    int               burst_left = 0;
    bit               gaps_on    = 1'b1;

    run_end_physical_span_lookup dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [VAL_W-1:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[VAL_W-1:0];
    endfunction

    // Upper-bound search over count entries from base; returns the position relative to base.
    function automatic logic [63:0] ub_search(input logic [63:0] base, input logic [63:0] count,
                                              input logic [VAL_W-1:0] key);
        logic [63:0]      first;
        logic [63:0]      half;
        logic [63:0]      mid;
        logic [VAL_W-1:0] val;
        first = base;
        while (count > 0) begin
            half = count >> 1;
            mid  = first + half;
            val  = (mid < TABLE_DEPTH) ? shadow_ends[mid[IDX_W-1:0]] : '0;
            if (!(key < val)) begin
                first = mid + 1;
                count = count - half - 1;
            end else begin
                count = half;
            end
        end
        return first - base;
    endfunction

    // Physical offset and run count of a logical slice under the current table.
    function automatic span_t predict_span(input logic [VAL_W-1:0] off, input logic [VAL_W-1:0] len);
        logic [63:0] n;
        logic [63:0] poff;
        logic [63:0] plen;
        logic [63:0] last;
        span_t       s;
        n    = (valid_runs > TABLE_DEPTH) ? 64'(TABLE_DEPTH) : 64'(valid_runs);
        poff = ub_search(64'd0, n, off);
        plen = '0;
        if (len != '0) begin
            last = {1'b0, off} + {1'b0, len} - 64'd1;
            if (last > {1'b0, MAX63})
                last = {1'b0, MAX63};
            plen = ub_search(poff, n - poff, last[VAL_W-1:0]) + 64'd1;
        end
        s.phys_off = poff[CNT_W-1:0];
        s.phys_len = plen[CNT_W-1:0];
        return s;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_request(input logic [IDX_W-1:0] idx,
                                                          input logic [VAL_W-1:0] run_end,
                                                          input logic [VAL_W-1:0] off,
                                                          input logic [VAL_W-1:0] len);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[ENTRY_LSB +: IDX_W]  = idx;
        d[RUNEND_LSB +: VAL_W] = run_end;
        d[OFFSET_LSB +: VAL_W] = off;
        d[LENGTH_LSB +: VAL_W] = len;
        return d;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Offer one request, track it in the predictor once accepted, then pace the sender.
    task automatic offer_request(input logic kind, input logic [S_TDATA_W-1:0] data,
                                 input logic pinned, input span_t pinned_span);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        if (kind == REQ_LOAD)
            shadow_ends[data[ENTRY_LSB +: IDX_W]] = data[RUNEND_LSB +: VAL_W];
        else if (pinned)
            span_q.push_back(pinned_span);
        else
            span_q.push_back(predict_span(data[OFFSET_LSB +: VAL_W], data[LENGTH_LSB +: VAL_W]));
        // Bursts of random length separated by random gaps.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = gaps_on ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Write run_count once every query has answered and any trailing load has settled.
    task automatic set_run_count(input logic [CNT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (span_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        valid_runs = value;
    endtask

    // Result checker: every accepted result is compared with the oldest expected span.
    initial begin : span_check
        span_t want;
        span_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.phys_off = m_tdata[0 +: CNT_W];
                got.phys_len = m_tdata[PLEN_LSB +: CNT_W];
                if (span_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result offset %0d length %0d",
                                              got.phys_off, got.phys_len));
                end else begin
                    want = span_q.pop_front();
                    if (got.phys_off !== want.phys_off)
                        report_mismatch($sformatf("physical_offset expected %0d got %0d",
                                                  want.phys_off, got.phys_off));
                    if (got.phys_len !== want.phys_len)
                        report_mismatch($sformatf("physical_length expected %0d got %0d",
                                                  want.phys_len, got.phys_len));
                end
            end
        end
    end

    // Result receiver: changing stall patterns, plus long hold-offs that back up the block.
    initial begin : result_sink
        rx_mode_t mode;
        int       cyc;
        int       dwell;
        int       hold_left;
        mode      = RX_OPEN;
        cyc       = 0;
        dwell     = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (dwell == 0) begin
                mode  = rx_mode_t'($urandom_range(0, 3));
                dwell = $urandom_range(50, 400);
            end
            dwell--;
            if (cyc % 9000 == 4000)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:  m_tready <= 1'b1;
                    RX_COIN:  m_tready <= ($urandom_range(0, 3) != 0);
                    RX_BEAT:  m_tready <= (cyc % 5 < 3);
                    default:  m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Main sequence: reset, directed rows, random phases, drain and verdict.
    initial begin : stimulus
        span_t            no_span;
        int               n;
        int               nv;
        int               phase;
        int               body_items;
        int               nq;
        int               j;
        logic [VAL_W-1:0] cur;
        logic [VAL_W-1:0] off;
        logic [VAL_W-1:0] len;
        logic [31:0]      step_max;

        no_span = '0;
        foreach (shadow_ends[i])
            shadow_ends[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows.
        for (int r = 0; r < DIR_ROWS; r++) begin
            case (dir_rows[r].op)
                ROW_COUNT: set_run_count(dir_rows[r].run_end[CNT_W-1:0]);
                ROW_LOAD:  offer_request(REQ_LOAD, pack_request(dir_rows[r].idx,
                               dir_rows[r].run_end, rand63(), rand63()), 1'b0, no_span);
                default:   offer_request(REQ_QUERY, pack_request(IDX_W'($urandom),
                               rand63(), dir_rows[r].offset, dir_rows[r].length),
                               dir_rows[r].pinned, dir_rows[r].span);
            endcase
        end

        // Random phases: set run_count, optionally reload an increasing table, then queries.
        phase      = 0;
        body_items = 0;
        while (body_items < RANDOM_ITEMS) begin
            if (phase == 0) begin
                n = TABLE_DEPTH;
            end else if (phase == 1) begin
                n = (1 << CNT_W) - 1;
            end else begin
                case ($urandom_range(0, 19))
                    0:       n = 0;
                    1:       n = TABLE_DEPTH;
                    default: n = $urandom_range(1, 40);
                endcase
            end
            set_run_count(CNT_W'(n));
            nv      = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
            gaps_on = ($urandom_range(0, 3) != 0);

            // The first phase fills the whole table, so every later count reads loaded entries.
            if (phase == 0 || (nv <= 64 && $urandom_range(0, 9) < 7)) begin
                case ($urandom_range(0, 2))
                    0:       cur = VAL_W'($urandom_range(0, 3));
                    1:       cur = {23'd0, 40'(rand63())};
                    default: cur = {2'b10, 61'(rand63())};
                endcase
                case ($urandom_range(0, 2))
                    0:       step_max = 32'd4;
                    1:       step_max = 32'd1000;
                    default: step_max = 32'h8000_0000;
                endcase
                for (int e = 0; e < nv; e++) begin
                    offer_request(REQ_LOAD, pack_request(IDX_W'(e), cur, rand63(), rand63()),
                                  1'b0, no_span);
                    cur = cur + VAL_W'($urandom_range(1, step_max));
                end
            end

            nq = $urandom_range(15, 50);
            repeat (nq) begin
                if ($urandom_range(0, 7) == 0) begin
                    // Stray load anywhere in the table; inside the count it breaks the ordering.
                    offer_request(REQ_LOAD, pack_request(IDX_W'($urandom), rand63(), rand63(),
                                  rand63()), 1'b0, no_span);
                end else begin
                    j = (nv > 0) ? $urandom_range(0, nv - 1) : 0;
                    case ($urandom_range(0, 9))
                        0:       off = '0;
                        1:       off = MAX63;
                        2:       off = rand63();
                        default: begin
                            off = (nv > 0) ? shadow_ends[j] : rand63();
                            case ($urandom_range(0, 2))
                                0:       if (off != '0) off = off - 1;
                                1:       if (off != MAX63) off = off + 1;
                                default: ;
                            endcase
                        end
                    endcase
                    j = (nv > 0) ? $urandom_range(0, nv - 1) : 0;
                    case ($urandom_range(0, 9))
                        0:       len = '0;
                        1:       len = MAX63;
                        2:       len = rand63();
                        3, 4:    len = 63'd1;
                        default: begin
                            if (nv > 0 && shadow_ends[j] > off)
                                len = shadow_ends[j] - off + VAL_W'($urandom_range(0, 2));
                            else
                                len = VAL_W'($urandom_range(1, 64));
                        end
                    endcase
                    offer_request(REQ_QUERY, pack_request(IDX_W'($urandom), rand63(), off, len),
                                  1'b0, no_span);
                end
                body_items++;
            end
            phase++;
        end

        // Drain outstanding results, then allow a quiet spell for stray outputs.
        s_tvalid <= 1'b0;
        while (span_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
